// File: rtl/core/cbl_pkg.sv
`default_nettype none
package cbl_pkg;

  localparam int MASK_W   = 32;
  localparam int BLOCK_W  = 3;
  localparam int BIT_W    = 5;
  localparam int LIGHT_W  = 8;
  localparam int CLNUM_W  = 12;
  localparam int OFFSET_W = 21;
  localparam int TOTAL_W  = 9;
  localparam int COUNT_W  = 9;

  localparam int MAX_LIGHTS_DEF    = 256;
  localparam int CLUSTER_COUNT_DEF = 4096;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;

  typedef enum logic {
    KIND_LIGHT   = 1'b0,
    KIND_CLUSTER = 1'b1
  } record_kind_t;

  // One queued word: the mask already has uncounted blocks zeroed.
  typedef struct packed {
    logic [MASK_W-1:0]  mask;
    logic [BLOCK_W-1:0] block;
    logic               frame_start;
    logic               cluster_end;
  } cbl_word_t;

  // Index of the single set bit of a one-hot word.
  function automatic logic [BIT_W-1:0] onehot_index(input logic [MASK_W-1:0] onehot);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (onehot[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/cbl_front.sv
`default_nettype none
module cbl_front #(
  parameter int MAX_LIGHTS = cbl_pkg::MAX_LIGHTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [cbl_pkg::COUNT_W-1:0]   cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cbl_pkg::MASK_W-1:0]    mask_word,
  input  wire logic [cbl_pkg::BLOCK_W-1:0]   block_number,
  input  wire logic                          frame_start,
  input  wire logic                          cluster_end,
  input  wire logic                          q_full,
  output logic                               q_push,
  output cbl_pkg::cbl_word_t                 q_data
);
  import cbl_pkg::*;

  localparam int LW = 11;
  localparam logic [LW-1:0] MaxLights = LW'(MAX_LIGHTS);

  logic [COUNT_W-1:0] light_count;
  logic [LW-1:0]      lights;
  logic               counted;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_count <= '0;
    end else if (cfg_we) begin
      light_count <= cfg_wdata;
    end
  end

  // A block counts when its first light lies below the clamped light count.
  always_comb begin
    lights  = (LW'(light_count) > MaxLights) ? MaxLights : LW'(light_count);
    counted = (LW'({block_number, 5'b00000}) < lights);
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.mask        = counted ? mask_word : '0;
    q_data.block       = block_number;
    q_data.frame_start = frame_start;
    q_data.cluster_end = cluster_end;
  end

endmodule
`default_nettype wire

// File: rtl/core/cbl_queue.sv
`default_nettype none
module cbl_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire cbl_pkg::cbl_word_t push_data,
  output logic             full,
  input  wire logic        pop,
  output logic             not_empty,
  output cbl_pkg::cbl_word_t pop_data
);
  import cbl_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cbl_word_t         slots [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/core/cbl_back.sv
`default_nettype none
module cbl_back #(
  parameter int CLUSTER_COUNT = cbl_pkg::CLUSTER_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_not_empty,
  input  wire cbl_pkg::cbl_word_t             q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                record_kind,
  output logic [cbl_pkg::LIGHT_W-1:0]         light_number,
  output logic [cbl_pkg::CLNUM_W-1:0]         cluster_number,
  output logic [cbl_pkg::OFFSET_W-1:0]        list_offset,
  output logic [cbl_pkg::TOTAL_W-1:0]         cluster_light_total,
  output logic                                last
);
  import cbl_pkg::*;

  localparam int CW = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
  localparam int XW = (CW > CLNUM_W) ? CW : CLNUM_W;

  logic [OFFSET_W-1:0] running_offset;
  logic [CW-1:0]       cluster_no;
  logic [OFFSET_W-1:0] cluster_start;
  logic [TOTAL_W-1:0]  cluster_total;
  logic                cluster_open;

  logic [MASK_W-1:0]   cur_mask;
  logic [BLOCK_W-1:0]  cur_block;
  logic                cur_end;

  logic                busy;
  logic                emit;
  logic                light_emit;
  logic                cluster_emit;
  logic [MASK_W-1:0]   low_bit;
  logic [MASK_W-1:0]   rest_mask;
  logic [BIT_W-1:0]    bit_idx;
  logic [OFFSET_W-1:0] ro_base;
  logic [CW-1:0]       cno_base;
  logic                open_base;
  logic [XW-1:0]       cno_ext;

  assign busy         = (cur_mask != '0) || cur_end;
  assign q_pop        = q_not_empty && !busy;
  assign emit         = busy && (!out_valid || out_ready);
  assign light_emit   = emit && (cur_mask != '0);
  assign cluster_emit = emit && (cur_mask == '0);

  // Isolate the lowest set bit; the rest of the mask waits for later cycles.
  assign low_bit   = cur_mask & (~cur_mask + MASK_W'(1));
  assign rest_mask = cur_mask & ~low_bit;
  assign bit_idx   = onehot_index(low_bit);
  assign cno_ext   = XW'(cluster_no);

  always_comb begin
    ro_base   = q_data.frame_start ? '0 : running_offset;
    cno_base  = q_data.frame_start ? '0 : cluster_no;
    open_base = q_data.frame_start ? 1'b0 : cluster_open;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_offset <= '0;
      cluster_no     <= '0;
      cluster_start  <= '0;
      cluster_total  <= '0;
      cluster_open   <= 1'b0;
      cur_mask       <= '0;
      cur_end        <= 1'b0;
      cur_block      <= '0;
    end else if (q_pop) begin
      running_offset <= ro_base;
      cluster_no     <= cno_base;
      cluster_open   <= 1'b1;
      if (!open_base) begin
        cluster_start <= ro_base;
        cluster_total <= '0;
      end
      cur_mask  <= q_data.mask;
      cur_block <= q_data.block;
      cur_end   <= q_data.cluster_end;
    end else if (light_emit) begin
      cur_mask <= rest_mask;
      if (running_offset != OFFSET_MAX) begin
        running_offset <= running_offset + OFFSET_W'(1);
      end
      if (cluster_total != TOTAL_MAX) begin
        cluster_total <= cluster_total + TOTAL_W'(1);
      end
    end else if (cluster_emit) begin
      cur_end      <= 1'b0;
      cluster_open <= 1'b0;
      cluster_no   <= (cluster_no == CW'(CLUSTER_COUNT - 1)) ? '0 : cluster_no + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (light_emit) begin
      record_kind         <= KIND_LIGHT;
      light_number        <= {cur_block, bit_idx};
      cluster_number      <= cno_ext[CLNUM_W-1:0];
      list_offset         <= running_offset;
      cluster_light_total <= '0;
      last                <= (rest_mask == '0) && !cur_end;
    end else if (cluster_emit) begin
      record_kind         <= KIND_CLUSTER;
      light_number        <= '0;
      cluster_number      <= cno_ext[CLNUM_W-1:0];
      list_offset         <= cluster_start;
      cluster_light_total <= cluster_total;
      last                <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_cluster_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (record_kind == KIND_CLUSTER) |-> last)
    else $error("cluster record not marked last");
  a_busy_open: assert property (@(posedge clk) disable iff (rst)
    busy |-> cluster_open) else $error("word in progress without an open cluster");
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_data.frame_start |=> (running_offset == '0) && (cluster_no == '0))
    else $error("frame start did not clear the offset");
`endif

endmodule
`default_nettype wire

// File: rtl/core/cluster_bitmask_list_compactor_top.sv
// Cluster bitmask list compactor.
// Input channel (in_valid/in_ready): one 32-bit membership word per transfer, with its
// block number, a frame_start flag and a cluster_end flag. Words of blocks at or beyond
// ceil(light_count/32) contribute no lights; their cluster_end still counts.
// Output channel (out_valid/out_ready): one record per transfer. A light record gives
// block*32+bit for each set bit, lowest first; a cluster record follows a cluster's last
// word with its list offset and light total. last marks a word's final record.
// light_count is written through cfg_we/cfg_wdata; write it only while the block is idle, which it does not enforce.
// Words enter a two-entry queue from the front; the back pops a word only when it holds
// no unfinished word and then emits one record per cycle while the output is not stalled:
// one light record per counted set bit, then a cluster record if cluster_end is set. The
// first record of a word passes the queue, the back's current word and the output register.
// When the receiver stalls, the output register holds its record, the back stops and
// the queue fills; in_ready falls only once the queue is full.
// Reset clears light_count to zero, the running offset, cluster number, the queue and
// out_valid; the record fields of the output register are not reset.
`default_nettype none
module cluster_bitmask_list_compactor_top #(
  parameter int MAX_LIGHTS    = cbl_pkg::MAX_LIGHTS_DEF,
  parameter int CLUSTER_COUNT = cbl_pkg::CLUSTER_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [cbl_pkg::COUNT_W-1:0]   cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cbl_pkg::MASK_W-1:0]    mask_word,
  input  wire logic [cbl_pkg::BLOCK_W-1:0]   block_number,
  input  wire logic                          frame_start,
  input  wire logic                          cluster_end,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               record_kind,
  output logic [cbl_pkg::LIGHT_W-1:0]        light_number,
  output logic [cbl_pkg::CLNUM_W-1:0]        cluster_number,
  output logic [cbl_pkg::OFFSET_W-1:0]       list_offset,
  output logic [cbl_pkg::TOTAL_W-1:0]        cluster_light_total,
  output logic                               last
);
  import cbl_pkg::*;

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_not_empty;
  cbl_word_t q_in;
  cbl_word_t q_out;

  cbl_front #(.MAX_LIGHTS(MAX_LIGHTS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mask_word    (mask_word),
    .block_number (block_number),
    .frame_start  (frame_start),
    .cluster_end  (cluster_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  cbl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  cbl_back #(.CLUSTER_COUNT(CLUSTER_COUNT)) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_not_empty         (q_not_empty),
    .q_data              (q_out),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .record_kind         (record_kind),
    .light_number        (light_number),
    .cluster_number      (cluster_number),
    .list_offset         (list_offset),
    .cluster_light_total (cluster_light_total),
    .last                (last)
  );

endmodule
`default_nettype wire
